// ===== rtl/core/lbp3_pkg.sv =====
// lbp3_pkg: shared types and constants for the 3x3 LBP code stream block.
// No dependencies; imported by lbp_3x3_code_stream_top and its testbench.
package lbp3_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned COL_W   = 11;
  localparam int unsigned FW_W    = 12;
  localparam int unsigned FH_W    = 13;
  localparam int unsigned CFG_W   = 13;

  // Configuration register indexes
  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  localparam logic [FW_W-1:0] FW_RESET = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;

  // Code bit positions per neighbor
  localparam int unsigned BIT_LEFT        = 7;
  localparam int unsigned BIT_BELOW_LEFT  = 6;
  localparam int unsigned BIT_BELOW       = 5;
  localparam int unsigned BIT_BELOW_RIGHT = 4;
  localparam int unsigned BIT_RIGHT       = 3;
  localparam int unsigned BIT_ABOVE_RIGHT = 2;
  localparam int unsigned BIT_ABOVE       = 1;
  localparam int unsigned BIT_ABOVE_LEFT  = 0;

  // Result queue
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = 2;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              last;
  } result_t;

endpackage

// ===== rtl/core/lbp_3x3_code_stream_top.sv =====
// lbp_3x3_code_stream_top: streaming 3x3 local binary pattern (8 neighbors).
// Depends on lbp3_pkg and lbp3_ram.
//
// Accepts one 8-bit grey pixel per clock in raster order and emits one LBP
// code per interior centre, tagged with the centre's row and column and a
// last flag on the final interior code of the frame. A pixel beat is taken in
// every cycle while the result queue has room; with the output side never
// stalling the block runs at one pixel per clock indefinitely. An accepted
// pixel passes the registered read of the line-buffer RAM and then the
// compare stage that writes the four-entry result queue before its code
// reaches the output port. in_stall_o rises only when the result queue
// (plus the beat in the compare stage) could fill, i.e. when the
// output side has been stalling. The two line buffers share one RAM of
// MAX_WIDTH words, 16 bits each (upper byte = row above, lower byte = middle
// row); it is read at the column of the incoming beat and written back at the
// column of the beat in the compare stage, which is always a different
// column. The RAM needs no clearing pass: in normal use no entry feeds a
// code before it is written. Frame geometry is clamped to [3, MAX_WIDTH] and
// [3, MAX_HEIGHT]; write it only while the block is idle.
module lbp_3x3_code_stream_top
  import lbp3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  // pixel input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PIX_W-1:0]    pixel_i,
  // code output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CODE_W-1:0]   code_o,
  output logic [ROW_W-1:0]    out_row_o,
  output logic [COL_W-1:0]    out_col_o,
  output logic                last_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  // ---------------------------------------------------------------- config
  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_RESET;
      frame_height_q <= FH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // Effective (clamped) geometry
  logic [CW:0] w_eff;
  logic [RW:0] h_eff;

  always_comb begin
    priority if (frame_width_q < FW_W'(3)) begin
      w_eff = (CW+1)'(3);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(frame_width_q);
    end
  end

  always_comb begin
    priority if (frame_height_q < FH_W'(3)) begin
      h_eff = (RW+1)'(3);
    end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (RW+1)'(frame_height_q);
    end
  end

  // ------------------------------------------------------ input / counters
  logic          in_acc;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          col_wrap, row_wrap;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign col_wrap = ({1'b0, col_q} + (CW+1)'(1)) >= w_eff;
  assign row_wrap = ({1'b0, row_q} + (RW+1)'(1)) >= h_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Compare stage registers (beat plus its position)
  logic             b_valid_q;
  logic [PIX_W-1:0] b_pix_q;
  logic [CW-1:0]    b_col_q;
  logic [RW-1:0]    b_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      b_pix_q <= pixel_i;
      b_col_q <= col_q;
      b_row_q <= row_q;
    end
  end

  // ------------------------------------------------------- line buffers
  logic [2*PIX_W-1:0] line_rdata;
  logic [PIX_W-1:0]   top, mid, bot;

  lbp3_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_col_q),
    .wdata_i ({mid, bot}),
    .raddr_i (col_q),
    .rdata_o (line_rdata)
  );

  assign top = line_rdata[2*PIX_W-1:PIX_W];
  assign mid = line_rdata[PIX_W-1:0];
  assign bot = b_pix_q;

  // ------------------------------------------------------- 3x3 window
  // win_q[0..2]: column c-2 (top, mid, bot); win_q[3..5]: column c-1.
  logic [PIX_W-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (b_valid_q) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= bot;
    end
  end

  // ------------------------------------------------------- code compute
  logic [PIX_W-1:0]  ctr;
  logic [CODE_W-1:0] code_c;
  logic              b_interior;
  logic              b_emit;
  result_t           res_c;

  assign ctr = win_q[4];

  always_comb begin
    code_c                  = '0;
    code_c[BIT_LEFT]        = win_q[1] > ctr;
    code_c[BIT_BELOW_LEFT]  = win_q[2] > ctr;
    code_c[BIT_BELOW]       = win_q[5] > ctr;
    code_c[BIT_BELOW_RIGHT] = bot > ctr;
    code_c[BIT_RIGHT]       = mid > ctr;
    code_c[BIT_ABOVE_RIGHT] = top > ctr;
    code_c[BIT_ABOVE]       = win_q[3] > ctr;
    code_c[BIT_ABOVE_LEFT]  = win_q[0] > ctr;
  end

  logic [RW-1:0] row_m1;
  logic [CW-1:0] col_m1;

  assign row_m1 = b_row_q - RW'(1);
  assign col_m1 = b_col_q - CW'(1);

  assign b_interior = (b_row_q >= RW'(2)) && (b_col_q >= CW'(2)) &&
                      ({1'b0, b_row_q} < h_eff) && ({1'b0, b_col_q} < w_eff);
  assign b_emit     = b_valid_q && b_interior;

  assign res_c.code = code_c;
  assign res_c.row  = ROW_W'(row_m1);
  assign res_c.col  = COL_W'(col_m1);
  assign res_c.last = ({1'b0, b_row_q} == h_eff - (RW+1)'(1)) &&
                      ({1'b0, b_col_q} == w_eff - (CW+1)'(1));

  // ------------------------------------------------------- result queue
  result_t          rq_q [RQ_DEPTH];
  logic [RQ_AW-1:0] rq_wptr_q, rq_rptr_q;
  logic [RQ_AW:0]   rq_cnt_q, rq_cnt_d;
  logic             rq_pop;

  assign rq_pop = out_valid_o && !out_stall_i;

  always_comb begin
    rq_cnt_d = rq_cnt_q;
    if (b_emit && !rq_pop) begin
      rq_cnt_d = rq_cnt_q + (RQ_AW+1)'(1);
    end else if (!b_emit && rq_pop) begin
      rq_cnt_d = rq_cnt_q - (RQ_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wptr_q <= '0;
      rq_rptr_q <= '0;
      rq_cnt_q  <= '0;
    end else begin
      rq_cnt_q <= rq_cnt_d;
      if (b_emit) begin
        rq_wptr_q <= rq_wptr_q + RQ_AW'(1);
      end
      if (rq_pop) begin
        rq_rptr_q <= rq_rptr_q + RQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_emit) begin
      rq_q[rq_wptr_q] <= res_c;
    end
  end

  // Room check: queued results plus the beat in the compare stage, plus
  // the beat about to enter, must fit.
  assign in_stall_o = ({1'b0, rq_cnt_q} + (RQ_AW+2)'(b_valid_q)) >= (RQ_AW+2)'(RQ_DEPTH);

  assign out_valid_o = rq_cnt_q != '0;
  assign code_o      = rq_q[rq_rptr_q].code;
  assign out_row_o   = rq_q[rq_rptr_q].row;
  assign out_col_o   = rq_q[rq_rptr_q].col;
  assign last_o      = rq_q[rq_rptr_q].last;

  // ------------------------------------------------------- assertions
  a_rq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_emit |-> (rq_cnt_q < (RQ_AW+1)'(RQ_DEPTH)) || rq_pop)
    else $error("result queue overflow");

  a_rq_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_cnt_q <= (RQ_AW+1)'(RQ_DEPTH))
    else $error("result queue count out of range");

  a_beat_to_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> b_valid_q && (b_pix_q == $past(pixel_i)))
    else $error("accepted beat not in compare stage");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && col_wrap && row_wrap |=> (col_q == '0) && (row_q == '0))
    else $error("counters did not wrap at frame end");

endmodule

// ===== rtl/core/lbp3_ram.sv =====
// lbp3_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lbp3_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for lbp_3x3_code_stream_top, the streaming 3x3 LBP coder.
// Depends on lbp3_pkg and the RTL of lbp_3x3_code_stream_top and lbp3_ram; needs nothing else.
// A beat-level predictor of the line buffers and window checks every code beat in order.
module testbench;
  import lbp3_pkg::*;

  localparam int unsigned MAX_W = 2048;
  localparam int unsigned MAX_H = 4096;
  localparam int unsigned IDLE_PCT = 26;          // percent of cycles each side idles
  localparam int unsigned HOLD_CYCLES = 300;      // long output hold-off
  localparam int unsigned SETTLE_CYCLES = 8;      // two-stage pipe plus margin
  localparam int unsigned RANDOM_TARGET = 630;    // pixel beats before the closing frames
  localparam int unsigned CYCLE_LIMIT = 500000;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [PIX_W-1:0] pixel_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [CODE_W-1:0] code_o;
  logic [ROW_W-1:0] out_row_o;
  logic [COL_W-1:0] out_col_o;
  logic last_o;

  always #5 clk_i = ~clk_i;

  lbp_3x3_code_stream_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_i    (pixel_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .code_o     (code_o),
    .out_row_o  (out_row_o),
    .out_col_o  (out_col_o),
    .last_o     (last_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the geometry registers, the two line buffers,
  // the two trailing window columns and the raster position of the next pixel.
  // ---------------------------------------------------------------------------
  logic [FW_W-1:0] frame_w_reg;
  logic [FH_W-1:0] frame_h_reg;
  bit [PIX_W-1:0] line_above [MAX_W];   // row r-2 at each column
  bit [PIX_W-1:0] line_mid [MAX_W];     // row r-1 at each column
  bit [1:0] touch_cnt [MAX_W];          // writes per column, saturating at 2
  bit [PIX_W-1:0] win_near [3];         // column c-1: above, centre row, below
  bit [PIX_W-1:0] win_far [3];          // column c-2: same order
  int unsigned col_pos;
  int unsigned row_pos;

  // Stimulus and scoreboard storage
  logic [PIX_W-1:0] pixel_backlog [$];  // pixels not yet offered
  result_t pending_codes [$];           // predicted codes, oldest first
  result_t fresh;
  result_t oldest;

  // Run control shared between the processes
  bit quiet_run = 1'b0;                 // no idling on either side
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int unsigned hold_left = 0;

  // Statistics and verdict
  int unsigned err_cnt = 0;
  int unsigned beats_in = 0;
  int unsigned codes_checked = 0;
  int unsigned frames_seen = 0;
  int unsigned stalled_cycles = 0;
  int unsigned fed_total = 0;
  int unsigned cycle_no = 0;

  // Geometry as the block uses it: clamped to [3, hi]
  function automatic int unsigned eff_dim(input int unsigned raw, input int unsigned hi);
    if (raw < 3) return 3;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // One pixel through the window; returns 1 with the code when a centre completes
  function automatic bit lbp_window_step(input logic [PIX_W-1:0] px, output result_t res);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    bit [PIX_W-1:0] up;
    bit [PIX_W-1:0] mid;
    bit [PIX_W-1:0] ctr;
    bit hit;
    w = eff_dim(frame_w_reg, MAX_W);
    h = eff_dim(frame_h_reg, MAX_H);
    c = col_pos;
    r = row_pos;
    up = '0;
    mid = '0;
    hit = 1'b0;
    res = '0;
    if (c < MAX_W) begin
      up = line_above[c];
      mid = line_mid[c];
      line_above[c] = mid;
      line_mid[c] = px;
      if (touch_cnt[c] < 2) touch_cnt[c]++;
    end
    if (r >= 2 && c >= 2 && r < h && c < w) begin
      ctr = win_near[1];
      res.code[BIT_LEFT]        = win_far[1] > ctr;
      res.code[BIT_BELOW_LEFT]  = win_far[2] > ctr;
      res.code[BIT_BELOW]       = win_near[2] > ctr;
      res.code[BIT_BELOW_RIGHT] = px > ctr;
      res.code[BIT_RIGHT]       = mid > ctr;
      res.code[BIT_ABOVE_RIGHT] = up > ctr;
      res.code[BIT_ABOVE]       = win_near[0] > ctr;
      res.code[BIT_ABOVE_LEFT]  = win_far[0] > ctr;
      res.row = ROW_W'(r - 1);
      res.col = COL_W'(c - 1);
      res.last = (r == h - 1) && (c == w - 1);
      hit = 1'b1;
    end
    win_far = win_near;
    win_near[0] = up;
    win_near[1] = mid;
    win_near[2] = px;
    // position wraps at or beyond the limits, which matters after a mid-frame change
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    return hit;
  endfunction

  // Leading columns whose both buffer rows hold written data
  function automatic int unsigned seasoned_width();
    int unsigned n;
    n = 0;
    while (n < MAX_W && touch_cnt[n] >= 2) n++;
    return n;
  endfunction

  // Pixels still needed to bring the raster position back to (0,0)
  function automatic int unsigned pixels_to_frame_end();
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned n;
    w = eff_dim(frame_w_reg, MAX_W);
    h = eff_dim(frame_h_reg, MAX_H);
    c = col_pos;
    r = row_pos;
    n = 0;
    while (c != 0 || r != 0) begin
      n++;
      if (c + 1 >= w) begin
        c = 0;
        r = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        c++;
      end
    end
    return n;
  endfunction

  // Pixel content styles: full range, narrow band (many ties), black/white, flat
  function automatic logic [PIX_W-1:0] pick_pixel(input int unsigned style,
                                                  input int unsigned base);
    case (style)
      0: return PIX_W'($urandom_range(0, 255));
      1: return PIX_W'($urandom_range(base - 2, base + 2));
      2: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return PIX_W'(base);
    endcase
  endfunction

  task automatic feed_pixels(input int unsigned n, input int unsigned style);
    int unsigned base;
    base = $urandom_range(2, 253);
    repeat (n) pixel_backlog.push_back(pick_pixel(style, base));
    fed_total += n;
  endtask

  // Register write; only called while the block is idle
  task automatic program_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == CFG_FRAME_WIDTH) frame_w_reg = val[FW_W-1:0];
    else frame_h_reg = val[FH_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sender pause: wait for every pixel to be taken and every code to come back
  task automatic settle();
    while (pixel_backlog.size() != 0 || in_valid_i || pending_codes.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    err_cnt++;
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers pixel beats from the backlog, idling at random. A stalled
  // beat is held unchanged; the predictor runs on every accepted beat.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      pixel_i <= '0;
      col_pos = 0;
      row_pos = 0;
      win_near = '{default: '0};
      win_far = '{default: '0};
      frame_w_reg = FW_RESET;
      frame_h_reg = FH_RESET;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        beats_in++;
        if (lbp_window_step(pixel_i, fresh)) pending_codes.push_back(fresh);
      end else if (in_valid_i) begin
        stalled_cycles++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pixel_backlog.size() != 0 &&
            (quiet_run || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid_i <= 1'b1;
          pixel_i <= pixel_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random output stalls plus one long hold-off; each code beat is
  // compared field by field with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_codes.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected code beat: expected none, got code %0d row %0d col %0d",
                   $time, code_o, out_row_o, out_col_o);
        end else begin
          oldest = pending_codes.pop_front();
          if (oldest.code !== code_o) note_mismatch("code", oldest.code, code_o);
          if (oldest.row !== out_row_o) note_mismatch("out_row", oldest.row, out_row_o);
          if (oldest.col !== out_col_o) note_mismatch("out_col", oldest.col, out_col_o);
          if (oldest.last !== last_o) note_mismatch("last", oldest.last, last_o);
          codes_checked++;
          if (oldest.last) frames_seen++;
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      out_stall_i <= (hold_left != 0) || (!quiet_run && $urandom_range(0, 99) < IDLE_PCT);
      if (hold_left != 0) hold_left--;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_no++;
    if (cycle_no > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d codes outstanding", cycle_no,
               pending_codes.size());
      $display("lbp_3x3_code_stream_top test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned lim;
    int unsigned w_raw;
    int unsigned h_raw;
    int unsigned n;
    int unsigned k;
    int unsigned style;
    bit first;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: width and height below the minimum clamp to 3. The centre sits
    // among equal, darker and brighter neighbors, so only strict ">" sets bits.
    program_reg(CFG_FRAME_WIDTH, 13'd2);
    program_reg(CFG_FRAME_HEIGHT, 13'd0);
    pixel_backlog = '{8'd101, 8'd100, 8'd99,
                      8'd100, 8'd100, 8'd101,
                      8'd99,  8'd101, 8'd100};
    fed_total += 9;
    settle();

    // Directed: width data with bit 12 set (masked to 4), height 1 clamps to 3.
    // Dark centre in a white ring gives all ones; white centre gives all zeros.
    program_reg(CFG_FRAME_WIDTH, 13'h1004);
    program_reg(CFG_FRAME_HEIGHT, 13'd1);
    pixel_backlog = '{8'd255, 8'd255, 8'd255, 8'd0,
                      8'd255, 8'd0,   8'd255, 8'd0,
                      8'd255, 8'd255, 8'd255, 8'd0};
    fed_total += 12;
    settle();

    // Mid-frame shrink of the width below the current column: wraps to column 0.
    program_reg(CFG_FRAME_WIDTH, 13'd10);
    program_reg(CFG_FRAME_HEIGHT, 13'd6);
    feed_pixels(2 * 10 + 7, 0);
    settle();
    program_reg(CFG_FRAME_WIDTH, 13'd5);
    feed_pixels(pixels_to_frame_end(), 0);
    settle();

    // Mid-frame shrink of the height below the current row: wraps to row 0.
    program_reg(CFG_FRAME_WIDTH, 13'd8);
    program_reg(CFG_FRAME_HEIGHT, 13'd8);
    feed_pixels(5 * 8 + 3, 1);
    settle();
    program_reg(CFG_FRAME_HEIGHT, 13'd4);
    feed_pixels(pixels_to_frame_end(), 1);
    settle();

    // Backpressure: the receiver holds off while a frame with many interior
    // centres streams in, so the result queue fills and the input stalls.
    program_reg(CFG_FRAME_WIDTH, 13'd12);
    program_reg(CFG_FRAME_HEIGHT, 13'd10);
    hold_req = 1'b1;
    feed_pixels(120, 0);

    // Random frames, mostly small, some back to back with the same geometry,
    // some with a geometry change in the middle (width grown only over
    // columns already written twice).
    first = 1'b1;
    while (fed_total < RANDOM_TARGET) begin
      if (first || $urandom_range(0, 1)) begin
        settle();
        w_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
        h_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
        program_reg(CFG_FRAME_WIDTH, CFG_W'(w_raw));
        program_reg(CFG_FRAME_HEIGHT, CFG_W'(h_raw));
        first = 1'b0;
      end
      style = $urandom_range(0, 3);
      n = eff_dim(frame_w_reg, MAX_W) * eff_dim(frame_h_reg, MAX_H);
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, n - 1);
        feed_pixels(k, style);
        settle();
        lim = seasoned_width();
        if (lim > 16) lim = 16;
        program_reg(CFG_FRAME_WIDTH, CFG_W'($urandom_range(3, lim)));
        program_reg(CFG_FRAME_HEIGHT, CFG_W'($urandom_range(3, 10)));
        feed_pixels(pixels_to_frame_end(), style);
      end else begin
        feed_pixels(n, style);
      end
    end
    settle();

    // Full frame with neither side idling for the whole stretch
    quiet_run = 1'b1;
    program_reg(CFG_FRAME_WIDTH, 13'd14);
    program_reg(CFG_FRAME_HEIGHT, 13'd10);
    feed_pixels(14 * 10, 0);
    settle();
    quiet_run = 1'b0;

    // Geometry beyond the maximum clamps to MAX_W x MAX_H; the first row of
    // such a frame, over columns already written, gives no code
    program_reg(CFG_FRAME_WIDTH, 13'd4095);
    program_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
    feed_pixels(12, 0);
    settle();

    $display("covered %0d pixel beats, %0d codes checked, %0d complete frames",
             beats_in, codes_checked, frames_seen);
    $display("clamped, random and mid-frame geometries, %0d cycles held by input stall",
             stalled_cycles);
    if (err_cnt == 0) begin
      $display("lbp_3x3_code_stream_top test passed");
    end else begin
      $display("lbp_3x3_code_stream_top test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lbp3_pkg.sv
rtl/core/lbp3_ram.sv
rtl/core/lbp_3x3_code_stream_top.sv
test/testbench.sv
